@@ hw/rtl/mple_pkg.sv @@
// ----------------------------------------------------------------------------
// mple_pkg: shared types and codes of the masked password line editor
// Key codes, result kinds and the control word that drives each storage cell.
// ----------------------------------------------------------------------------
package mple_pkg;

   // Width of one incoming key code and of one stored character.
   localparam int KEY_W  = 16;
   localparam int CHAR_W = 7;
   localparam int KIND_W = 3;

   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [KIND_W-1:0] kind_type;

   // Key codes that the editor reacts to.
   localparam key_type KEY_NUL         = 16'd0;
   localparam key_type KEY_EOT         = 16'd3;
   localparam key_type KEY_BS          = 16'd8;
   localparam key_type KEY_ENTER       = 16'd13;
   localparam key_type KEY_ESC         = 16'd27;
   localparam key_type KEY_FIRST_PRINT = 16'd32;
   localparam key_type KEY_LAST_PRINT  = 16'd126;

   // Result kinds.
   localparam kind_type KIND_STAR  = 3'd0;
   localparam kind_type KIND_ERASE = 3'd1;
   localparam kind_type KIND_CHAR  = 3'd2;
   localparam kind_type KIND_END   = 3'd3;
   localparam kind_type KIND_ABORT = 3'd4;

   // Control word broadcast to every cell of the character chain.
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

@@ hw/rtl/masked_password_line_editor.sv @@
// One key word is taken per accepted request. Printable keys, backspace,
// end-of-text, key 0 and ignored keys start no sequence. After enter the
// editor sends one word per stored character, then the line-end word; after
// escape it sends one erase echo per stored character. The stored line is a
// chain of cells that moves one character per cycle, unless the response
// side stalls, toward the single output register, and the erase echoes leave
// through that register one per cycle under the same condition. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
// masked_password_line_editor: hidden line editor with masked echo
// Edits a line held in a chain of character cells and returns echo, line
// and abort words on the response channel.
// ----------------------------------------------------------------------------
module masked_password_line_editor #(
   parameter int CAPACITY = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mple_pkg::key_type    req_key_code,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mple_pkg::kind_type   rsp_kind,
   output mple_pkg::char_type   rsp_char_value,
   output logic                 rsp_last
);
   import mple_pkg::*;

   localparam int DEPTH = CAPACITY - 1;
   localparam int CNT_W = $clog2(CAPACITY);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EMIT  = 2'd1;
   localparam logic [1:0] ST_ERASE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic             skip_ff, skip_in;

   logic             rsp_valid_ff, rsp_valid_in;
   kind_type         rsp_kind_ff, rsp_kind_in;
   char_type         rsp_char_ff, rsp_char_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             out_free;
   logic             out_load;
   logic             req_accept;
   logic             is_print;
   cell_ctl_type     cell_ctl;
   char_type         cell_value [DEPTH];

   // The chain of character cells; cell 0 is the oldest character.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      char_type shift_src;
      if (g == DEPTH - 1) begin : g_top
         assign shift_src = '0;
      end else begin : g_mid
         assign shift_src = cell_value[g+1];
      end
      mple_cell #(
         .ADDR_W (CNT_W),
         .INDEX  (g)
      ) u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .load_addr (count_ff),
         .load_data (req_key_code[CHAR_W-1:0]),
         .shift_in  (shift_src),
         .value     (cell_value[g])
      );
   end

   // Handshake: the output register is free when empty or being taken.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign is_print   = (req_key_code >= KEY_FIRST_PRINT) &&
                       (req_key_code <= KEY_LAST_PRINT);

   // Key decoding and the sequencer for multi-word responses.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      rem_in         = rem_ff;
      skip_in        = skip_ff;
      out_load       = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_char_in    = rsp_char_ff;
      rsp_last_in    = rsp_last_ff;
      cell_ctl.shift = 1'b0;
      cell_ctl.load  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (skip_ff) begin
                  skip_in = 1'b0;
               end else if (req_key_code == KEY_ENTER) begin
                  state_in = ST_EMIT;
                  rem_in   = count_ff;
               end else if ((req_key_code == KEY_BS) && (count_ff != '0)) begin
                  count_in    = count_ff - ONE_C;
                  out_load    = 1'b1;
                  rsp_kind_in = KIND_ERASE;
                  rsp_char_in = '0;
                  rsp_last_in = 1'b1;
               end else if (req_key_code == KEY_ESC) begin
                  if (count_ff != '0) begin
                     state_in = ST_ERASE;
                     rem_in   = count_ff;
                     count_in = '0;
                  end
               end else if (req_key_code == KEY_EOT) begin
                  count_in    = '0;
                  out_load    = 1'b1;
                  rsp_kind_in = KIND_ABORT;
                  rsp_char_in = '0;
                  rsp_last_in = 1'b1;
               end else if (req_key_code == KEY_NUL) begin
                  skip_in = 1'b1;
               end else if (is_print && (count_ff < DEPTH_C)) begin
                  cell_ctl.load = 1'b1;
                  count_in      = count_ff + ONE_C;
                  out_load      = 1'b1;
                  rsp_kind_in   = KIND_STAR;
                  rsp_char_in   = '0;
                  rsp_last_in   = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            // Stream the line out of cell 0, then close it with a line end.
            if (out_free) begin
               out_load = 1'b1;
               if (rem_ff != '0) begin
                  cell_ctl.shift = 1'b1;
                  rem_in         = rem_ff - ONE_C;
                  rsp_kind_in    = KIND_CHAR;
                  rsp_char_in    = cell_value[0];
                  rsp_last_in    = 1'b0;
               end else begin
                  count_in    = '0;
                  state_in    = ST_IDLE;
                  rsp_kind_in = KIND_END;
                  rsp_char_in = '0;
                  rsp_last_in = 1'b1;
               end
            end
         end
         ST_ERASE: begin
            // One erase echo per character that was on the line.
            if (out_free) begin
               out_load    = 1'b1;
               rem_in      = rem_ff - ONE_C;
               rsp_kind_in = KIND_ERASE;
               rsp_char_in = '0;
               rsp_last_in = (rem_ff == ONE_C);
               if (rem_ff == ONE_C) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         skip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_char_value = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("Character count exceeds the line depth.");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("Request taken while a response sequence is running.");

   a_erase_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ERASE) |-> ((count_ff == '0) && (rem_ff != '0)))
      else $error("Erase sequence with a live line or no erases left.");

   a_emit_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (rem_ff <= count_ff))
      else $error("Line output runs past the stored characters.");

   a_char_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff != KIND_CHAR)) |-> (rsp_char_ff == '0))
      else $error("Character value set on a word that carries no character.");
`endif

endmodule

@@ hw/rtl/mple_cell.sv @@
// ----------------------------------------------------------------------------
// mple_cell: one character cell of the line chain
// Holds one stored character. It loads a new key when the write address
// matches its own position and takes its upper neighbor's character on a shift.
// ----------------------------------------------------------------------------
module mple_cell #(
   parameter int ADDR_W = 5,
   parameter int INDEX  = 0
) (
   input  logic                  clock,
   input  mple_pkg::cell_ctl_type ctl,
   input  logic [ADDR_W-1:0]     load_addr,
   input  mple_pkg::char_type    load_data,
   input  mple_pkg::char_type    shift_in,
   output mple_pkg::char_type    value
);
   import mple_pkg::*;

   localparam logic [ADDR_W-1:0] MY_ADDR = ADDR_W'(INDEX);

   char_type value_ff;
   char_type value_in;

   // A shift moves the chain down by one cell; a load writes this cell only.
   always_comb begin
      value_in = value_ff;
      if (ctl.shift) begin
         value_in = shift_in;
      end else if (ctl.load && (load_addr == MY_ADDR)) begin
         value_in = load_data;
      end
   end

   // Character storage needs no reset.
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
